// ===== hw/rtl/rau_pkg.sv =====
// Shared types and constants of the rational arithmetic unit.
// Depends on nothing; used by every module of the block.
package rau_pkg;

	localparam int unsigned NumW   = 32;
	localparam int unsigned DenW   = 31;
	localparam int unsigned WideW  = 64;
	localparam int unsigned FracW  = 63;
	localparam int unsigned InDataW  = 128;
	localparam int unsigned OutDataW = 192;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// Classified request handed from front to back.
	typedef struct packed {
		logic                 inf;
		logic                 zero;
		logic                 neg;
		logic [WideW-1:0]     num;
		logic [WideW-1:0]     den;
	} job_t;

	typedef struct packed {
		logic                 is_infinite;
		logic                 negative;
		logic [WideW-1:0]     whole_part;
		logic [FracW-1:0]     frac_numerator;
		logic [FracW-1:0]     frac_denominator;
	} res_t;

endpackage

// ===== hw/rtl/rau_front.sv =====
// Front part: accepts requests, forms raw numerator and denominator.
// Depends on rau_pkg. Two registered stages: multiply, then combine.
module rau_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         operation,
	input  logic signed [rau_pkg::NumW-1:0]    left_numerator,
	input  logic [rau_pkg::DenW-1:0]           left_denominator,
	input  logic signed [rau_pkg::NumW-1:0]    right_numerator,
	input  logic [rau_pkg::DenW-1:0]           right_denominator,
	output logic                               job_valid,
	input  logic                               job_ready,
	output rau_pkg::job_t                      job
);

	logic        v_s1;
	logic [1:0]  op_s1;
	logic        neg_s1;
	logic        rz_s1;
	logic signed [rau_pkg::WideW-1:0] x_s1;
	logic signed [rau_pkg::WideW-1:0] y_s1;
	logic [rau_pkg::WideW-1:0]        d_s1;
	logic        v_s2;
	rau_pkg::job_t job_s2;

	logic [rau_pkg::NumW-1:0] la, ra;
	logic signed [rau_pkg::WideW-1:0] x_d, y_d;
	logic [rau_pkg::WideW-1:0] d_d;
	logic adv2, adv1;
	logic signed [rau_pkg::WideW-1:0] r;
	rau_pkg::job_t j_d;

	assign adv2 = !v_s2 || job_ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;
	assign job_valid = v_s2;
	assign job = job_s2;

	// abs of 32-bit signed fits in 32 unsigned bits
	assign la = left_numerator[rau_pkg::NumW-1] ? rau_pkg::NumW'(-left_numerator)
		: rau_pkg::NumW'(left_numerator);
	assign ra = right_numerator[rau_pkg::NumW-1] ? rau_pkg::NumW'(-right_numerator)
		: rau_pkg::NumW'(right_numerator);

	always_comb begin
		unique case (rau_pkg::op_t'(operation))
			rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
				x_d = 64'(left_numerator) * $signed({33'd0, right_denominator});
				y_d = 64'(right_numerator) * $signed({33'd0, left_denominator});
				d_d = 64'(left_denominator) * 64'(right_denominator);
			end
			rau_pkg::OP_MUL: begin
				x_d = $signed(64'(la) * 64'(ra));
				y_d = '0;
				d_d = 64'(left_denominator) * 64'(right_denominator);
			end
			default: begin
				x_d = $signed(64'(la) * 64'(right_denominator));
				y_d = '0;
				d_d = 64'(left_denominator) * 64'(ra);
			end
		endcase
	end

	always_comb begin
		r = (rau_pkg::op_t'(op_s1) == rau_pkg::OP_SUB) ? x_s1 - y_s1 : x_s1 + y_s1;
		j_d = '0;
		if (rau_pkg::op_t'(op_s1) == rau_pkg::OP_ADD
			|| rau_pkg::op_t'(op_s1) == rau_pkg::OP_SUB) begin
			j_d.neg = r[rau_pkg::WideW-1];
			j_d.num = r[rau_pkg::WideW-1] ? 64'(-r) : 64'(r);
		end else begin
			j_d.neg = neg_s1;
			j_d.num = 64'(x_s1);
		end
		j_d.den = d_s1;
		j_d.inf = (rau_pkg::op_t'(op_s1) == rau_pkg::OP_DIV && rz_s1) || d_s1 == '0;
		j_d.zero = j_d.num == '0;
		if (j_d.inf) begin
			j_d.neg = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			op_s1  <= operation;
			x_s1   <= x_d;
			y_s1   <= y_d;
			d_s1   <= d_d;
			rz_s1  <= right_numerator == '0;
			neg_s1 <= left_numerator[rau_pkg::NumW-1] ^ right_numerator[rau_pkg::NumW-1];
		end
		if (adv2 && v_s1) begin
			job_s2 <= j_d;
		end
	end

endmodule

// ===== hw/rtl/rau_queue.sv =====
// Two-entry queue that decouples the front part from the back part.
// Depends on rau_pkg for the request type.
module rau_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  rau_pkg::job_t  wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output rau_pkg::job_t  rd_data
);

	rau_pkg::job_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

endmodule

// ===== hw/rtl/rau_back.sv =====
// Back part: restoring divide for whole part; with a remainder, Euclidean gcd by
// repeated bit-serial remainder, then two divides to reduce. Depends on rau_pkg.
module rau_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  rau_pkg::job_t  job,
	output logic           res_valid,
	input  logic           res_ready,
	output rau_pkg::res_t  res
);

	typedef enum logic [2:0] {
		S_IDLE, S_WHOLE, S_GCD, S_RN, S_RD, S_OUT
	} state_t;

	state_t state_q;
	logic [5:0] bit_q;
	logic [rau_pkg::WideW-1:0] dvd_q, dvs_q, quo_q, rem_q;
	logic [rau_pkg::WideW-1:0] den_q, remv_q, ga_q, gb_q, whole_q, fn_q;
	logic neg_q;
	// finished result, held until the output register is free
	rau_pkg::res_t fin_q;
	rau_pkg::res_t res_q;
	logic res_v_q;

	// one restoring step
	logic [rau_pkg::WideW:0] sh;
	logic [rau_pkg::WideW-1:0] nrem, nquo;
	logic ge;

	assign sh = {rem_q, dvd_q[6'(rau_pkg::WideW-1) - bit_q]};
	assign ge = sh >= {1'b0, dvs_q};
	assign nrem = ge ? 64'(sh - {1'b0, dvs_q}) : 64'(sh);
	assign nquo = {quo_q[rau_pkg::WideW-2:0], ge};

	assign job_ready = state_q == S_IDLE;
	assign res_valid = res_v_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_v_q <= 1'b0;
			bit_q   <= '0;
		end else begin
			if (state_q == S_OUT && (!res_v_q || res_ready)) begin
				res_v_q <= 1'b1;
			end else if (res_ready) begin
				res_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						den_q <= job.den;
						neg_q <= job.neg;
						if (job.inf || job.zero) begin
							fin_q.is_infinite <= job.inf;
							fin_q.negative <= 1'b0;
							fin_q.whole_part <= '0;
							fin_q.frac_numerator <= '0;
							fin_q.frac_denominator <= job.inf ? '0 : 63'd1;
							state_q <= S_OUT;
						end else begin
							dvd_q <= job.num;
							dvs_q <= job.den;
							rem_q <= '0;
							quo_q <= '0;
							bit_q <= '0;
							state_q <= S_WHOLE;
						end
					end
				end
				S_WHOLE, S_GCD, S_RN, S_RD: begin
					if (bit_q == 6'(rau_pkg::WideW-1)) begin
						bit_q <= '0;
						rem_q <= '0;
						quo_q <= '0;
						priority case (state_q)
							S_WHOLE: begin
								whole_q <= nquo;
								remv_q <= nrem;
								if (nrem == '0) begin
									fn_q <= '0;
									dvs_q <= 64'd1;
									state_q <= S_RD;
									dvd_q <= 64'd1;
								end else begin
									// gcd(rem, den): b % a with a = rem
									ga_q <= nrem;
									dvd_q <= den_q;
									dvs_q <= nrem;
									state_q <= S_GCD;
								end
							end
							S_GCD: begin
								if (nrem == '0) begin
									dvd_q <= remv_q;
									dvs_q <= ga_q;
									gb_q <= ga_q;
									state_q <= S_RN;
								end else begin
									ga_q <= nrem;
									dvd_q <= dvs_q;
									dvs_q <= nrem;
								end
							end
							S_RN: begin
								fn_q <= nquo;
								dvd_q <= den_q;
								dvs_q <= gb_q;
								state_q <= S_RD;
							end
							default: begin
								fin_q.is_infinite <= 1'b0;
								fin_q.negative <= neg_q;
								fin_q.whole_part <= whole_q;
								fin_q.frac_numerator <= fn_q[rau_pkg::FracW-1:0];
								fin_q.frac_denominator <= (remv_q == '0) ? 63'd1
									: nquo[rau_pkg::FracW-1:0];
								state_q <= S_OUT;
							end
						endcase
					end else begin
						rem_q <= nrem;
						quo_q <= nquo;
						bit_q <= bit_q + 6'd1;
					end
				end
				default: begin
					// hand the result over once the output register is free
					if (!res_v_q || res_ready) begin
						res_q <= fin_q;
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit.
// Depends on rau_pkg, rau_front, rau_queue and rau_back.
//
// Takes two fractions and an operation (add, subtract, multiply, divide) and
// returns the result as a mixed number: sign, whole part and the remainder
// reduced by a Euclidean gcd. Zero divisor or zero raw denominator sets
// is_infinite with all other fields zero; a zero result gives 0 and 0/1.
// The front part forms the raw fraction in two stages and feeds a two-entry
// queue; the back part runs one shared 64-step restoring divider for the
// whole part, for each Euclid step of the gcd and for the final reduction.
// An exact quotient skips the gcd, and zero and infinite results skip the
// divider. The divider loop sets the rate.
module rational_arithmetic_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// operation[1:0], left_numerator[33:2], left_denominator[64:34],
	// right_numerator[96:65], right_denominator[127:97]
	input  logic [127:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// whole_part[63:0], frac_numerator[126:64], frac_denominator[189:127]
	output logic [191:0]  m_tdata,
	// is_infinite[0], negative[1]
	output logic [1:0]    m_tuser
);

	logic f_valid, f_ready, q_valid, q_ready;
	rau_pkg::job_t f_job, q_job;
	rau_pkg::res_t r;

	rau_front u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.operation(s_tdata[1:0]),
		.left_numerator($signed(s_tdata[33:2])),
		.left_denominator(s_tdata[64:34]),
		.right_numerator($signed(s_tdata[96:65])),
		.right_denominator(s_tdata[127:97]),
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	rau_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
	);

	rau_back u_back (
		.clk, .arst_n,
		.job_valid(q_valid), .job_ready(q_ready), .job(q_job),
		.res_valid(m_tvalid), .res_ready(m_tready), .res(r)
	);

	assign m_tdata = {2'b00, r.frac_denominator, r.frac_numerator, r.whole_part};
	assign m_tuser = {r.negative, r.is_infinite};

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for rational_arithmetic_unit.
// Depends on rau_pkg and the RTL; checks every result against an in-bench fraction predictor.
module tb_top;

	localparam int unsigned NUM_RANDOM  = 1330;
	localparam longint unsigned LIMIT   = 64'd40_000_000;
	localparam int unsigned HOLD_CYCLES = 3000;

	// Predicts each mixed-number result and matches results in order.
	class fraction_scoreboard;
		rau_pkg::res_t pending_results[$];
		int unsigned mismatches;
		int unsigned checked;

		function longint unsigned magnitude(longint v);
			return (v < 0) ? longint'(-v) : v;
		endfunction

		// Note one accepted request and queue the result it must produce.
		function void note_request(rau_pkg::op_t op, logic signed [31:0] ln, logic [30:0] ld,
				logic signed [31:0] rn, logic [30:0] rd);
			longint a, b, r;
			longint unsigned num, den, rem, g, x, t;
			bit neg;
			rau_pkg::res_t e;
			a = ln;
			b = rn;
			neg = 1'b0;
			num = 0;
			den = 0;
			case (op)
				rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
					r = (op == rau_pkg::OP_ADD) ? a * longint'(rd) + b * longint'(ld)
						: a * longint'(rd) - b * longint'(ld);
					neg = r < 0;
					num = magnitude(r);
					den = longint'(ld) * longint'(rd);
				end
				rau_pkg::OP_MUL: begin
					neg = (a < 0) != (b < 0);
					num = magnitude(a) * magnitude(b);
					den = longint'(ld) * longint'(rd);
				end
				default: begin
					if (b != 0) begin
						neg = (a < 0) != (b < 0);
						num = magnitude(a) * longint'(rd);
						den = longint'(ld) * magnitude(b);
					end
				end
			endcase
			e = '0;
			if (den == 0) begin
				e.is_infinite = 1'b1;
			end else if (num == 0) begin
				e.frac_denominator = 63'd1;
			end else begin
				e.negative = neg;
				e.whole_part = num / den;
				rem = num % den;
				e.frac_denominator = 63'd1;
				if (rem != 0) begin
					// Euclid on the remainder and the raw denominator
					x = rem;
					g = den;
					while (x != 0) begin
						t = g % x;
						g = x;
						x = t;
					end
					e.frac_numerator = 63'(rem / g);
					e.frac_denominator = 63'(den / g);
				end
			end
			pending_results.push_back(e);
		endfunction

		// Compare one result against the oldest expectation.
		function void check_result(rau_pkg::res_t got);
			rau_pkg::res_t e;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %p", got);
				return;
			end
			e = pending_results.pop_front();
			checked++;
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d mismatch\n  exp %p\n  got %p", checked, e, got);
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [127:0]  s_tdata;
	logic          m_tvalid;
	logic          m_tready;
	logic [191:0]  m_tdata;
	logic [1:0]    m_tuser;

	fraction_scoreboard fractions = new();
	longint unsigned cycle_count;
	bit calm_stretch;
	bit hold_request;
	int unsigned op_count [4];
	int unsigned zero_divisors;

	rational_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: drop out if the block stops answering.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, fractions.pending_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off when asked.
	initial begin
		int unsigned held;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
				hold_request = 1'b0;
			end
			m_tready <= calm_stretch || ($urandom_range(0, 99) >= 16);
		end
	end

	// Monitor: check every accepted result.
	always @(posedge clk) begin
		rau_pkg::res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.is_infinite = m_tuser[0];
			got.negative = m_tuser[1];
			got.whole_part = m_tdata[63:0];
			got.frac_numerator = m_tdata[126:64];
			got.frac_denominator = m_tdata[189:127];
			fractions.check_result(got);
		end
	end

	// Offer one request, with an occasional gap before it; return once accepted.
	task automatic send_request(rau_pkg::op_t op, logic signed [31:0] ln, logic [30:0] ld,
			logic signed [31:0] rn, logic [30:0] rd);
		if (!calm_stretch && $urandom_range(0, 99) < 16) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {rd, rn, ld, ln, op};
		do @(posedge clk); while (!s_tready);
		fractions.note_request(op, ln, ld, rn, rd);
		op_count[op]++;
		if (op == rau_pkg::OP_DIV && rn == 0)
			zero_divisors++;
	endtask

	function automatic logic signed [31:0] pick_numerator(int unsigned scale);
		case (scale)
			0: return 32'($signed($urandom_range(0, 511)) - 256);
			1: return 32'($signed($urandom_range(0, 131071)) - 65536);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] pick_denominator(int unsigned scale);
		case (scale)
			0: return 31'($urandom_range(1, 255));
			1: return 31'($urandom_range(1, 65535));
			default: return 31'($urandom_range(1, 32'h7fff_ffff));
		endcase
	endfunction

	initial begin
		localparam logic signed [31:0] NMIN = 32'sh8000_0000;
		localparam logic signed [31:0] NMAX = 32'sh7fff_ffff;
		localparam logic [30:0] DMAX = 31'h7fff_ffff;
		int unsigned i, scale;
		rau_pkg::op_t op;
		logic signed [31:0] ln, rn;
		logic [30:0] ld, rd;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cycle_count = 0;
		calm_stretch = 1'b0;
		hold_request = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, each operation, zero divisor, zero result, exact quotients.
		send_request(rau_pkg::OP_ADD, NMIN, 31'd1, NMIN, 31'd1);
		send_request(rau_pkg::OP_ADD, NMAX, DMAX, NMAX, DMAX);
		send_request(rau_pkg::OP_SUB, NMIN, DMAX, NMAX, 31'd1);
		send_request(rau_pkg::OP_SUB, NMAX, 31'd1, NMIN, DMAX);
		send_request(rau_pkg::OP_MUL, NMIN, 31'd1, NMIN, 31'd1);
		send_request(rau_pkg::OP_MUL, NMAX, DMAX, NMIN, DMAX);
		send_request(rau_pkg::OP_MUL, -32'sd1, DMAX, NMAX, 31'd3);
		send_request(rau_pkg::OP_DIV, NMIN, 31'd1, 32'sd1, DMAX);
		send_request(rau_pkg::OP_DIV, NMAX, DMAX, NMIN, 31'd1);
		send_request(rau_pkg::OP_DIV, 32'sd5, 31'd7, 32'sd0, 31'd3);
		send_request(rau_pkg::OP_DIV, 32'sd0, 31'd1, 32'sd0, DMAX);
		send_request(rau_pkg::OP_ADD, 32'sd0, 31'd9, 32'sd0, 31'd4);
		send_request(rau_pkg::OP_SUB, 32'sd3, 31'd4, 32'sd3, 31'd4);
		send_request(rau_pkg::OP_MUL, 32'sd0, DMAX, NMIN, 31'd1);
		send_request(rau_pkg::OP_DIV, 32'sd0, 31'd3, -32'sd7, 31'd2);
		send_request(rau_pkg::OP_ADD, 32'sd1, 31'd2, 32'sd1, 31'd2);
		send_request(rau_pkg::OP_MUL, 32'sd4, 31'd1, 32'sd6, 31'd3);
		send_request(rau_pkg::OP_DIV, -32'sd9, 31'd2, 32'sd3, 31'd2);
		send_request(rau_pkg::OP_SUB, -32'sd1, 31'd3, 32'sd1, 31'd6);
		send_request(rau_pkg::OP_ADD, -32'sd5, 31'd6, 32'sd1, 31'd4);

		// Random: mostly small operands to keep gcd chains short, some full width.
		for (i = 0; i < NUM_RANDOM; i++) begin
			calm_stretch = (i >= 500 && i < 700);
			if (i == 300)
				hold_request = 1'b1;
			scale = $urandom_range(0, 99);
			scale = (scale < 65) ? 0 : (scale < 88) ? 1 : 2;
			op = rau_pkg::op_t'($urandom_range(0, 3));
			ln = pick_numerator(scale);
			rn = pick_numerator(scale);
			ld = pick_denominator(scale);
			rd = pick_denominator(scale);
			if ($urandom_range(0, 99) < 4)
				rn = '0;
			if ($urandom_range(0, 99) < 3)
				ln = '0;
			send_request(op, ln, ld, rn, rd);
		end
		s_tvalid <= 1'b0;

		// Drain outstanding results, then let the back end settle.
		while (fractions.pending_results.size() != 0)
			@(posedge clk);
		repeat (800) @(posedge clk);

		$display("covered %0d add, %0d sub, %0d mul, %0d div requests (%0d with zero divisor)",
			op_count[rau_pkg::OP_ADD], op_count[rau_pkg::OP_SUB],
			op_count[rau_pkg::OP_MUL], op_count[rau_pkg::OP_DIV], zero_divisors);
		$display("%0d results checked, %0d mismatches", fractions.checked,
			fractions.mismatches);
		if (fractions.mismatches == 0 && fractions.pending_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
